/* design/b24kc_pkg.sv */
// Shared types, constants and helper functions for the base-24 key codec.
// No dependencies; used by b24kc_enc, b24kc_dec and base24_key_codec.
package b24kc_pkg;

  localparam int          MaxDigitsDef = 8;
  localparam int          PowEntries   = 14;
  localparam logic [3:0]  MaxCharsRst  = 4'd8;
  localparam logic [63:0] Base         = 64'd24;

  typedef logic [PowEntries-1:0][63:0] pow_tbl_t;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic {
    KIND_CHAR  = 1'b0,
    KIND_VALUE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] chr;
    logic       bad;
    logic       last;
  } enc_res_t;

  typedef struct packed {
    logic [63:0] value;
    logic        bad;
  } dec_res_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] digit;
  } dig_t;

  function automatic pow_tbl_t pow24_tbl();
    pow_tbl_t    tbl;
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < PowEntries; i++) begin
      tbl[i] = p;
      p      = p * Base;
    end
    return tbl;
  endfunction

  function automatic logic [7:0] digit_char(logic [4:0] d);
    logic [7:0] c;
    unique case (d)
      5'd0:  c = "b";
      5'd1:  c = "c";
      5'd2:  c = "d";
      5'd3:  c = "f";
      5'd4:  c = "g";
      5'd5:  c = "h";
      5'd6:  c = "j";
      5'd7:  c = "k";
      5'd8:  c = "m";
      5'd9:  c = "p";
      5'd10: c = "q";
      5'd11: c = "r";
      5'd12: c = "t";
      5'd13: c = "v";
      5'd14: c = "w";
      5'd15: c = "x";
      5'd16: c = "y";
      5'd17: c = "2";
      5'd18: c = "3";
      5'd19: c = "4";
      5'd20: c = "6";
      5'd21: c = "7";
      5'd22: c = "8";
      5'd23: c = "9";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic dig_t char_digit(logic [7:0] ch);
    logic [7:0] c;
    dig_t       r;
    c = ch;
    if (ch >= "A" && ch <= "Z") begin
      c = ch + 8'd32;
    end
    r.ok = 1'b1;
    unique case (c)
      "b": r.digit = 5'd0;
      "c": r.digit = 5'd1;
      "d": r.digit = 5'd2;
      "f": r.digit = 5'd3;
      "g": r.digit = 5'd4;
      "h": r.digit = 5'd5;
      "j": r.digit = 5'd6;
      "k": r.digit = 5'd7;
      "m": r.digit = 5'd8;
      "p": r.digit = 5'd9;
      "q": r.digit = 5'd10;
      "r": r.digit = 5'd11;
      "t": r.digit = 5'd12;
      "v": r.digit = 5'd13;
      "w": r.digit = 5'd14;
      "x": r.digit = 5'd15;
      "y": r.digit = 5'd16;
      "2": r.digit = 5'd17;
      "3": r.digit = 5'd18;
      "4": r.digit = 5'd19;
      "6": r.digit = 5'd20;
      "7": r.digit = 5'd21;
      "8": r.digit = 5'd22;
      "9": r.digit = 5'd23;
      default: begin
        r.ok    = 1'b0;
        r.digit = 5'd0;
      end
    endcase
    return r;
  endfunction

endpackage

/* design/b24kc_enc.sv */
// Encoder: digit-serial conversion of a value to base-24 characters, MSB first.
// Each digit is found by five restoring compare/subtract steps against 24^k.
// Depends on b24kc_pkg.
module b24kc_enc #(
  parameter int MAX_DIGITS = b24kc_pkg::MaxDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [63:0]         value_i,
  input  logic [3:0]          lim_i,
  output logic                busy_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output b24kc_pkg::enc_res_t res_o
);

  localparam int PosW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam b24kc_pkg::pow_tbl_t PowTbl = b24kc_pkg::pow24_tbl();
  localparam logic [63:0] Limit = PowTbl[MAX_DIGITS];
  localparam logic [PosW-1:0] TopPos = PosW'(MAX_DIGITS - 1);

  typedef enum logic [3:0] {
    E_IDLE  = 4'b0001,
    E_CHECK = 4'b0010,
    E_DIGIT = 4'b0100,
    E_EMIT  = 4'b1000
  } enc_state_e;

  enc_state_e          state_q, state_d;
  logic [63:0]         rem_q, rem_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [2:0]          bit_q, bit_d;
  logic [4:0]          dig_q, dig_d;
  logic [3:0]          cnt_q, cnt_d;
  b24kc_pkg::enc_res_t res_q, res_d;

  logic [63:0] step;
  logic        ge;
  logic [4:0]  dig_fin;
  logic        emit_now;

  assign step     = PowTbl[pos_q] << bit_q;
  assign ge       = (rem_q >= step);
  assign dig_fin  = dig_q | (5'(ge) << bit_q);
  assign emit_now = (cnt_q != 4'd0) || (dig_fin != 5'd0) || (pos_q == '0);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    bit_d   = bit_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    res_d   = res_q;
    unique case (state_q)
      E_IDLE: begin
        if (start_i) begin
          rem_d   = value_i;
          cnt_d   = 4'd0;
          state_d = E_CHECK;
        end
      end
      E_CHECK: begin
        pos_d = TopPos;
        bit_d = 3'd4;
        dig_d = 5'd0;
        if (rem_q >= Limit) begin
          res_d.chr  = 8'd0;
          res_d.bad  = 1'b1;
          res_d.last = 1'b1;
          state_d    = E_EMIT;
        end else begin
          state_d = E_DIGIT;
        end
      end
      E_DIGIT: begin
        if (ge) begin
          rem_d = rem_q - step;
        end
        dig_d = dig_fin;
        if (bit_q != 3'd0) begin
          bit_d = bit_q - 3'd1;
        end else if (emit_now) begin
          res_d.chr  = b24kc_pkg::digit_char(dig_fin);
          res_d.bad  = 1'b0;
          res_d.last = (pos_q == '0) || ({1'b0, cnt_q} + 5'd1 == {1'b0, lim_i});
          state_d    = E_EMIT;
        end else begin
          pos_d = pos_q - PosW'(1);
          bit_d = 3'd4;
          dig_d = 5'd0;
        end
      end
      E_EMIT: begin
        if (res_ready_i) begin
          if (res_q.last) begin
            state_d = E_IDLE;
          end else begin
            pos_d   = pos_q - PosW'(1);
            bit_d   = 3'd4;
            dig_d   = 5'd0;
            cnt_d   = cnt_q + 4'd1;
            state_d = E_DIGIT;
          end
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      cnt_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    pos_q <= pos_d;
    bit_q <= bit_d;
    dig_q <= dig_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != E_IDLE);
  assign res_valid_o = (state_q == E_EMIT);
  assign res_o       = res_q;

endmodule

/* design/b24kc_dec.sv */
// Decoder: folds one character per item into acc*24+digit over two add steps.
// Emits the value on the last character. Depends on b24kc_pkg.
module b24kc_dec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output logic                busy_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output b24kc_pkg::dec_res_t res_o
);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL  = 4'b0010,
    D_ADD  = 4'b0100,
    D_EMIT = 4'b1000
  } dec_state_e;

  dec_state_e  state_q, state_d;
  logic [63:0] acc_q, acc_d;
  logic        bad_q, bad_d;
  logic [4:0]  dig_q, dig_d;
  logic        last_q, last_d;

  b24kc_pkg::dig_t cd;

  assign cd = b24kc_pkg::char_digit(char_i);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    bad_d   = bad_q;
    dig_d   = dig_q;
    last_d  = last_q;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          last_d = last_i;
          dig_d  = cd.digit;
          if (!cd.ok) begin
            acc_d   = 64'd0;
            bad_d   = 1'b1;
            state_d = last_i ? D_EMIT : D_IDLE;
          end else begin
            state_d = D_MUL;
          end
        end
      end
      D_MUL: begin
        acc_d   = acc_q + {acc_q[62:0], 1'b0};
        state_d = D_ADD;
      end
      D_ADD: begin
        acc_d   = {acc_q[60:0], 3'b000} + 64'(dig_q);
        state_d = last_q ? D_EMIT : D_IDLE;
      end
      D_EMIT: begin
        if (res_ready_i) begin
          acc_d   = 64'd0;
          bad_d   = 1'b0;
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      acc_q   <= 64'd0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != D_IDLE);
  assign res_valid_o = (state_q == D_EMIT);
  assign res_o.value = bad_q ? 64'd0 : acc_q;
  assign res_o.bad   = bad_q;

endmodule

/* design/base24_key_codec.sv */
// Top level of the base-24 key codec: config register, engines, output register.
// Depends on b24kc_pkg, b24kc_enc and b24kc_dec.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | operation_i in_value_i in_char_i in_last_i
//  out     | source    | out_valid_o / out_stall_i| kind_o out_char_o out_value_o bad_o last_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_data_i (max_chars)
//
// Encode: each digit position is resolved by five compare/subtract steps, and each
// character is then held in the emit state until the output takes it.
// Decode: valid characters pass the multiply and add steps; invalid ones set bad.
// One item at a time; the output register holds a result while the next item enters.
// Reset clears both engines, the accumulator and sets max_chars to 8.
// A stalled output holds the engine in its emit state.
module base24_key_codec #(
  parameter int MAX_DIGITS = b24kc_pkg::MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [63:0] in_value_i,
  input  logic [7:0]  in_char_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_char_o,
  output logic [63:0] out_value_o,
  output logic        bad_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  localparam logic [3:0] MaxD = 4'(MAX_DIGITS);

  logic [3:0] max_chars_q;
  logic [3:0] lim;

  logic enc_busy, dec_busy, enc_valid, dec_valid;
  logic in_xfer, out_free;
  b24kc_pkg::enc_res_t enc_res;
  b24kc_pkg::dec_res_t dec_res;

  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  char_q, char_d;
  logic [63:0] value_q, value_d;
  logic        bad_q, bad_d;
  logic        last_q, last_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= b24kc_pkg::MaxCharsRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_chars_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (max_chars_q == 4'd0) begin
      lim = 4'd1;
    end else if (max_chars_q > MaxD) begin
      lim = MaxD;
    end else begin
      lim = max_chars_q;
    end
  end

  assign in_stall_o = enc_busy || dec_busy;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  b24kc_enc #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_enc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer && (operation_i == b24kc_pkg::OP_ENCODE)),
    .value_i     (in_value_i),
    .lim_i       (lim),
    .busy_o      (enc_busy),
    .res_valid_o (enc_valid),
    .res_ready_i (out_free),
    .res_o       (enc_res)
  );

  b24kc_dec u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer && (operation_i == b24kc_pkg::OP_DECODE)),
    .char_i      (in_char_i),
    .last_i      (in_last_i),
    .busy_o      (dec_busy),
    .res_valid_o (dec_valid),
    .res_ready_i (out_free),
    .res_o       (dec_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    char_d      = char_q;
    value_d     = value_q;
    bad_d       = bad_q;
    last_d      = last_q;
    if (out_free) begin
      out_valid_d = enc_valid || dec_valid;
      if (dec_valid) begin
        kind_d  = b24kc_pkg::KIND_VALUE;
        char_d  = 8'd0;
        value_d = dec_res.value;
        bad_d   = dec_res.bad;
        last_d  = 1'b1;
      end else begin
        kind_d  = b24kc_pkg::KIND_CHAR;
        char_d  = enc_res.chr;
        value_d = 64'd0;
        bad_d   = enc_res.bad;
        last_d  = enc_res.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    char_q  <= char_d;
    value_q <= value_d;
    bad_q   <= bad_d;
    last_q  <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign out_char_o  = char_q;
  assign out_value_o = value_q;
  assign bad_o       = bad_q;
  assign last_o      = last_q;

  a_one_engine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(enc_busy && dec_busy))
    else $error("both engines busy");

  a_encode_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && operation_i == b24kc_pkg::OP_ENCODE) |=> enc_busy)
    else $error("encode transfer did not start the encoder");

  a_value_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == b24kc_pkg::KIND_VALUE) |-> (last_o && out_char_o == 8'd0))
    else $error("decoded value result malformed");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_o) |-> (last_o && out_value_o == 64'd0))
    else $error("error result malformed");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((enc_valid || dec_valid) && !out_free) |=> (enc_valid || dec_valid))
    else $error("engine result dropped while output full");

endmodule
